// ===== rtl/core/bloom_filter_double_hash_assert.svh =====
// Assertion macros used by the checker file of this block.
// Each macro names its label, an antecedent, a consequent and a message.
// Clock clk and active-low reset rst_n must be in scope where they are used.
`ifndef BLOOM_FILTER_DOUBLE_HASH_ASSERT_SVH
`define BLOOM_FILTER_DOUBLE_HASH_ASSERT_SVH

// Same-cycle implication
`define BFDH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BFDH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bfdh_pkg.sv =====
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared widths, register indexes, command codes and control structs of the
// double-hash bloom filter.
// ----------------------------------------------------------------------------
package bfdh_pkg;

  // field and register widths
  localparam int HASH_W    = 64;
  localparam int BC_W      = 21;
  localparam int PC_W      = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = BC_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = 2'd1;

  // register reset values
  localparam logic [BC_W-1:0] BIT_COUNT_RST   = 21'd1048576;
  localparam logic [PC_W-1:0] PROBE_COUNT_RST = 6'd9;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // modulo reduction unit: bits retired per cycle
  localparam int RED_STEP   = 4;
  localparam int RED_CYCLES = HASH_W / RED_STEP;
  localparam int RED_CNT_W  = $clog2(RED_CYCLES);

  // 2^64 - 1, reduced to get 2^64 mod m
  localparam logic [HASH_W-1:0] ALL_ONES = {HASH_W{1'b1}};

  // reduction unit handshake
  typedef struct packed {
    logic start;
  } red_ctl_t;

  typedef struct packed {
    logic done;
  } red_stat_t;

  // bit store access request
  typedef struct packed {
    logic rd;
    logic wr;
  } store_req_t;

endpackage

// ===== rtl/core/bloom_filter_double_hash.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_double_hash
// Bloom filter bit store probed by double hashing, with a shared modulo unit.
// ----------------------------------------------------------------------------
// After reset the block sweeps its MAX_BITS-entry store to zero, one bit a
// cycle, and holds in_stall high until the sweep is over; configuration
// writes are taken during the sweep. Each item then takes one beat and is
// worked alone: three reductions modulo the bit count in the shared 4-bit-a-
// cycle reduction unit (a, b and 2^64-1, each with start and done), then
// one probe write after another for an insert, or for a query a registered
// memory read and a check per probe, stopping at the first clear bit. The
// next beat is taken only once the result is loaded into the output
// register. With k = 0 the item skips the reductions and probes and goes
// straight to its result. The result sits in an output register, and a
// new item is taken while it waits.
module bloom_filter_double_hash
  import bfdh_pkg::*;
#(
  parameter int MAX_BITS   = 1048576,
  parameter int MAX_PROBES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [HASH_W-1:0]     in_hash_a,
  input  logic [HASH_W-1:0]     in_hash_b,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_was_query,
  output logic                  out_not_present
);

  localparam int AW = $clog2(MAX_BITS);
  localparam int PW = $clog2(MAX_PROBES + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RED   = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // reduction operand select
  localparam logic [1:0] RED_A    = 2'd0;
  localparam logic [1:0] RED_B    = 2'd1;
  localparam logic [1:0] RED_ONES = 2'd2;

  logic [BC_W-1:0]   bit_count_r;
  logic [PC_W-1:0]   probe_count_r;
  logic [BC_W-1:0]   m_use;
  logic [PW-1:0]     k_use;

  logic [2:0]        state_r;
  logic [1:0]        red_sel_r;
  logic              red_start_r;
  logic              cmd_r;
  logic [HASH_W-1:0] a_r;
  logic [HASH_W-1:0] b_r;
  logic [HASH_W-1:0] x_r;
  logic [BC_W-1:0]   m_r;
  logic [PW-1:0]     k_r;
  logic [PW-1:0]     cnt_r;
  logic [BC_W-1:0]   r_r;
  logic [BC_W-1:0]   bm_r;
  logic [BC_W-1:0]   cm_r;
  logic              absent_r;
  logic              out_valid_r;
  logic              out_query_r;
  logic              out_absent_r;

  logic              in_beat;
  logic              out_load;
  logic [HASH_W-1:0] red_opnd;
  logic [BC_W-1:0]   red_rem;
  red_ctl_t          red_ctl;
  red_stat_t         red_stat;
  store_req_t        st_req;
  logic              st_rdata;
  logic              st_clearing;
  logic [BC_W:0]     cm_sum;

  logic [HASH_W:0]   x_sum;
  logic [BC_W:0]     t1;
  logic [BC_W-1:0]   t2;
  logic [BC_W:0]     t_wrap;
  logic [BC_W-1:0]   r_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r   <= BIT_COUNT_RST;
      probe_count_r <= PROBE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIT_COUNT:   bit_count_r   <= cfg_wdata[BC_W-1:0];
        REG_PROBE_COUNT: probe_count_r <= cfg_wdata[PC_W-1:0];
        default: ;
      endcase
    end
  end

  // effective bit count and probe count
  always_comb begin
    m_use = bit_count_r;
    if (bit_count_r == '0) begin
      m_use = BC_W'(1);
    end else if (32'(bit_count_r) > 32'(MAX_BITS)) begin
      m_use = BC_W'(MAX_BITS);
    end
    if (32'(probe_count_r) > 32'(MAX_PROBES)) begin
      k_use = PW'(MAX_PROBES);
    end else begin
      k_use = PW'(probe_count_r);
    end
  end

  // handshakes
  assign in_stall = (state_r != S_IDLE) | st_clearing;
  assign in_beat  = in_valid & ~in_stall;
  assign out_load = (state_r == S_DONE) & (~out_valid_r | ~out_stall);

  // shared reduction unit
  always_comb begin
    unique case (red_sel_r)
      RED_A:   red_opnd = a_r;
      RED_B:   red_opnd = b_r;
      default: red_opnd = ALL_ONES;
    endcase
  end

  assign red_ctl.start = red_start_r;

  bfdh_modred u_red (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (red_ctl),
    .operand (red_opnd),
    .modulus (m_r),
    .stat    (red_stat),
    .rem     (red_rem)
  );

  // 2^64 mod m from (2^64-1) mod m
  assign cm_sum = {1'b0, red_rem} + (BC_W + 1)'(1);

  // next probe position: x += b wraps at 2^64, so r tracks x mod m
  assign x_sum  = {1'b0, x_r} + {1'b0, b_r};
  assign t1     = {1'b0, r_r} + {1'b0, bm_r};
  assign t2     = (t1 >= {1'b0, m_r}) ? BC_W'(t1 - {1'b0, m_r}) : t1[BC_W-1:0];
  assign t_wrap = {1'b0, t2} + {1'b0, m_r} - {1'b0, cm_r};

  always_comb begin
    r_nxt = t2;
    if (x_sum[HASH_W]) begin
      if (t2 >= cm_r) begin
        r_nxt = t2 - cm_r;
      end else begin
        r_nxt = t_wrap[BC_W-1:0];
      end
    end
  end

  // bit store
  assign st_req.wr = (state_r == S_PROBE) & (cmd_r == CMD_INSERT);
  assign st_req.rd = (state_r == S_PROBE) & (cmd_r == CMD_QUERY);

  bfdh_store #(
    .DEPTH (MAX_BITS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (st_req),
    .addr     (AW'(r_r)),
    .rdata    (st_rdata),
    .clearing (st_clearing)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      red_start_r <= 1'b0;
      red_sel_r   <= RED_A;
    end else begin
      // kick the reduction unit on a new beat with nonzero k and after the a and b results
      red_start_r <= ((state_r == S_IDLE) & in_beat & (k_use != '0)) |
                     ((state_r == S_RED) & red_stat.done & (red_sel_r != RED_ONES));
      unique case (state_r)
        S_IDLE: begin
          if (in_beat) begin
            if (k_use == '0) begin
              state_r <= S_DONE;
            end else begin
              state_r   <= S_RED;
              red_sel_r <= RED_A;
            end
          end
        end
        S_RED: begin
          if (red_stat.done) begin
            unique case (red_sel_r)
              RED_A:   red_sel_r <= RED_B;
              RED_B:   red_sel_r <= RED_ONES;
              default: state_r   <= S_PROBE;
            endcase
          end
        end
        S_PROBE: begin
          if (cmd_r == CMD_QUERY) begin
            state_r <= S_CHECK;
          end else if (cnt_r == k_r - PW'(1)) begin
            state_r <= S_DONE;
          end
        end
        S_CHECK: begin
          if (!st_rdata || cnt_r == k_r) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_PROBE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_r    <= in_cmd;
      a_r      <= in_hash_a;
      b_r      <= in_hash_b;
      x_r      <= in_hash_a;
      m_r      <= m_use;
      k_r      <= k_use;
      cnt_r    <= '0;
      absent_r <= 1'b0;
    end
    if (state_r == S_RED && red_stat.done) begin
      unique case (red_sel_r)
        RED_A:   r_r  <= red_rem;
        RED_B:   bm_r <= red_rem;
        default: cm_r <= (cm_sum == {1'b0, m_r}) ? '0 : cm_sum[BC_W-1:0];
      endcase
    end
    if (state_r == S_PROBE) begin
      x_r   <= x_sum[HASH_W-1:0];
      r_r   <= r_nxt;
      cnt_r <= cnt_r + PW'(1);
    end
    if (state_r == S_CHECK && !st_rdata) begin
      absent_r <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r & out_stall) | out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_query_r  <= (cmd_r == CMD_QUERY);
      out_absent_r <= (cmd_r == CMD_QUERY) & absent_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_was_query   = out_query_r;
  assign out_not_present = out_absent_r;

endmodule

// ===== rtl/core/bfdh_modred.sv =====
// ----------------------------------------------------------------------------
// bfdh_modred
// Shared restoring reduction unit: a 64-bit operand modulo a 21-bit modulus,
// RED_STEP bits per cycle, most significant bits first.
// ----------------------------------------------------------------------------
module bfdh_modred
  import bfdh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  red_ctl_t          ctl,
  input  logic [HASH_W-1:0] operand,
  input  logic [BC_W-1:0]   modulus,
  output red_stat_t         stat,
  output logic [BC_W-1:0]   rem
);

  logic                 busy_r;
  logic                 done_r;
  logic [RED_CNT_W-1:0] cnt_r;
  logic [HASH_W-1:0]    val_r;
  logic [BC_W-1:0]      rem_r;
  logic [BC_W-1:0]      rem_nxt;

  // RED_STEP shift / compare / subtract steps on the running remainder
  always_comb begin
    logic [BC_W:0] t;
    rem_nxt = rem_r;
    for (int j = 0; j < RED_STEP; j++) begin
      t = {rem_nxt, val_r[HASH_W-1-j]};
      if (t >= {1'b0, modulus}) begin
        t = t - {1'b0, modulus};
      end
      rem_nxt = t[BC_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses for one cycle after the last step
      done_r <= ~ctl.start & busy_r & (cnt_r == RED_CNT_W'(RED_CYCLES - 1));
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + RED_CNT_W'(1);
        if (cnt_r == RED_CNT_W'(RED_CYCLES - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      val_r <= operand;
      rem_r <= '0;
    end else if (busy_r) begin
      val_r <= val_r << RED_STEP;
      rem_r <= rem_nxt;
    end
  end

  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

// ===== rtl/core/bfdh_store.sv =====
// ----------------------------------------------------------------------------
// bfdh_store
// Single-bit filter memory with one access port and a registered read.
// A clearing pass after reset writes every entry to zero.
// ----------------------------------------------------------------------------
module bfdh_store
  import bfdh_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  store_req_t    req,
  input  logic [AW-1:0] addr,
  output logic          rdata,
  output logic          clearing
);

  logic          mem [DEPTH];
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic          rdata_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_data;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // write port mux: sweep has priority
  assign wr_en   = clr_busy_r | req.wr;
  assign wr_addr = clr_busy_r ? clr_addr_r : addr;
  assign wr_data = ~clr_busy_r;

  // memory array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata    = rdata_r;
  assign clearing = clr_busy_r;

endmodule

// ===== rtl/core/bfdh_checker.sv =====
// ----------------------------------------------------------------------------
// bfdh_checker
// Port-level assertions for the bloom filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "bloom_filter_double_hash_assert.svh"

module bfdh_checker
  import bfdh_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  in_cmd,
  input logic [HASH_W-1:0]     in_hash_a,
  input logic [HASH_W-1:0]     in_hash_b,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_was_query,
  input logic                  out_not_present
);

  // a stalled result beat stays up
  `BFDH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped")

  // a stalled result beat keeps its payload
  `BFDH_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
    $stable(out_was_query) && $stable(out_not_present), "result payload changed")

  // a stalled input beat keeps its payload
  `BFDH_ASSERT_NEXT(a_in_stable, in_valid && in_stall,
    $stable(in_cmd) && $stable(in_hash_a) && $stable(in_hash_b), "input payload changed")

  // an insert acknowledge never reports absence
  `BFDH_ASSERT_NOW(a_ins_ack, out_valid && !out_was_query, !out_not_present,
    "insert acknowledge with not_present set")

  // one item at a time: busy right after an input beat
  `BFDH_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall,
    "input taken twice in a row")

endmodule

bind bloom_filter_double_hash bfdh_checker u_bfdh_checker (.*);

// ===== test/bloom_filter_double_hash_test.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_test
// Self-checking bench for the double-hash bloom filter. A directed table
// covers the extremes and the odd register settings (zero, oversized and
// out-of-range writes), then randomized phases each set a bit count and a
// probe count and mix inserts, queries of inserted keys and random queries.
// A software copy of the bit store predicts every result beat.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_test;
  import bfdh_pkg::*;

  // mirror of the block's default sizes
  localparam int STORE_BITS   = 1048576;
  localparam int STORE_AW     = $clog2(STORE_BITS);
  localparam int PROBE_LIMIT  = 32;

  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 83;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 150;
  localparam int POOL_MAX     = 64;
  // the clearing sweep plus every item at its slowest, several times over
  localparam longint TIMEOUT_TICKS = 64'd16_000_000;

  // indexes past the register list, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [HASH_W-1:0] H_ZERO = '0;
  localparam logic [HASH_W-1:0] H_ONES = '1;

  typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_e;
  // how a directed row is checked
  typedef enum logic [1:0] {CHK_MODEL, CHK_PRESENT, CHK_ABSENT} row_chk_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  cmd;
    logic [HASH_W-1:0]     a;
    logic [HASH_W-1:0]     b;
    row_chk_e              chk;
  } dir_row_t;

  typedef struct packed {
    logic was_query;
    logic not_present;
  } answer_t;

  typedef struct packed {
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } key_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BIT_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_cmd = CMD_INSERT;
  logic [HASH_W-1:0]     in_hash_a = '0;
  logic [HASH_W-1:0]     in_hash_b = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_was_query;
  logic                  out_not_present;

  // software copy of the filter and its registers
  bit                    filter_model [0:STORE_BITS-1];
  logic [BC_W-1:0]       model_bit_count = BIT_COUNT_RST;
  logic [PC_W-1:0]       model_probe_count = PROBE_COUNT_RST;

  answer_t               answers_due [$];
  answer_t               answer_head;
  dir_row_t              dir_table [$];
  key_t                  key_pool [$];

  int                    fail_count = 0;
  int                    results_seen = 0;
  int                    send_idle_pct = 20;
  int                    recv_idle_pct = 20;
  int                    stall_left = 0;
  bit                    hold_done = 1'b0;

  bloom_filter_double_hash DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_hash_a      (in_hash_a),
    .in_hash_b      (in_hash_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_was_query  (out_was_query),
    .out_not_present(out_not_present)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // modulus in use: zero reads as one, oversized saturates
  function automatic logic [HASH_W-1:0] live_modulus();
    if (model_bit_count == '0) return 64'd1;
    if (model_bit_count > STORE_BITS) return 64'(STORE_BITS);
    return 64'(model_bit_count);
  endfunction

  function automatic int unsigned live_probes();
    if (model_probe_count > PROBE_LIMIT) return PROBE_LIMIT;
    return model_probe_count;
  endfunction

  // walk the probes of one key; inserts set bits, queries stop at a clear one
  function automatic logic probe_filter_model(input logic cmd, input logic [HASH_W-1:0] a,
                                              input logic [HASH_W-1:0] b);
    logic [HASH_W-1:0] m;
    logic [HASH_W-1:0] pos;
    int unsigned       k;
    logic              absent;
    m = live_modulus();
    k = live_probes();
    absent = 1'b0;
    for (int unsigned i = 0; i < k && !absent; i++) begin
      // pos < m <= STORE_BITS, so the low bits address the whole store
      pos = (a + 64'(i) * b) % m;
      if (cmd == CMD_QUERY) begin
        if (!filter_model[pos[STORE_AW-1:0]]) absent = 1'b1;
      end else begin
        filter_model[pos[STORE_AW-1:0]] = 1'b1;
      end
    end
    return absent;
  endfunction

  function automatic dir_row_t item_row(input logic cmd, input logic [HASH_W-1:0] a,
                                        input logic [HASH_W-1:0] b, input row_chk_e chk);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.cmd = cmd;
    r.a = a;
    r.b = b;
    r.chk = chk;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    r.chk = CHK_MODEL;
    return r;
  endfunction

  // mostly full-width random, with the corners mixed in
  function automatic logic [HASH_W-1:0] rand_hash();
    case ($urandom_range(0, 15))
      0:       return H_ZERO;
      1:       return H_ONES;
      2:       return 64'($urandom_range(0, 255));
      3:       return {$urandom, 32'hFFFF_FFFF};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pick_idle(input int pct);
    if ($urandom_range(0, 99) < pct) return $urandom_range(1, 5);
    return 0;
  endfunction

  // offer one input beat, then log its predicted answer once taken
  task automatic drive_item(input logic cmd, input logic [HASH_W-1:0] a,
                            input logic [HASH_W-1:0] b, input row_chk_e chk);
    int      gap;
    answer_t ans;
    gap = pick_idle(send_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_hash_a <= a;
    in_hash_b <= b;
    do @(posedge clk); while (in_stall);
    ans.was_query = (cmd == CMD_QUERY);
    ans.not_present = probe_filter_model(cmd, a, b);
    if (chk == CHK_PRESENT) ans.not_present = 1'b0;
    else if (chk == CHK_ABSENT) ans.not_present = 1'b1;
    answers_due.push_back(ans);
  endtask

  // stop sending and let every outstanding answer come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_BIT_COUNT) model_bit_count = data;
    else if (idx == REG_PROBE_COUNT) model_probe_count = data[PC_W-1:0];
  endtask

  // result side: check each accepted beat, and stall in bursts
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (answers_due.size() == 0) begin
          $error("unexpected result beat: was_query %0b not_present %0b",
                 out_was_query, out_not_present);
          fail_count++;
        end else begin
          answer_head = answers_due.pop_front();
          if (out_was_query !== answer_head.was_query) begin
            $error("was_query mismatch: expected %0b, got %0b",
                   answer_head.was_query, out_was_query);
            fail_count++;
          end
          if (out_not_present !== answer_head.not_present) begin
            $error("not_present mismatch: expected %0b, got %0b",
                   answer_head.not_present, out_not_present);
            fail_count++;
          end
        end
      end
      // one long hold-off mid run so the block backs up into its input
      if (!hold_done && results_seen >= HOLD_AT) begin
        stall_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (stall_left == 0) begin
        stall_left = pick_idle(recv_idle_pct);
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    #TIMEOUT_TICKS;
    $display("bloom_filter_double_hash_test: FAIL");
    $finish;
  end

  initial begin
    logic [BC_W-1:0] bits;
    logic [PC_W-1:0] probes;
    int              roll;
    key_t            key;

    // reset settings: 2^20 bits, 9 probes, empty store
    dir_table.push_back(item_row(CMD_QUERY,  H_ZERO, H_ZERO, CHK_ABSENT));
    dir_table.push_back(item_row(CMD_QUERY,  H_ONES, H_ONES, CHK_ABSENT));
    dir_table.push_back(item_row(CMD_INSERT, H_ZERO, H_ZERO, CHK_MODEL));
    dir_table.push_back(item_row(CMD_QUERY,  H_ZERO, H_ZERO, CHK_PRESENT));
    dir_table.push_back(item_row(CMD_QUERY,  64'd1048576, H_ZERO, CHK_PRESENT));
    dir_table.push_back(item_row(CMD_INSERT, H_ONES, H_ONES, CHK_MODEL));
    dir_table.push_back(item_row(CMD_QUERY,  H_ONES, H_ONES, CHK_PRESENT));
    dir_table.push_back(item_row(CMD_INSERT, 64'd1, 64'd1, CHK_MODEL));
    dir_table.push_back(item_row(CMD_QUERY,  64'd1, 64'd2, CHK_MODEL));
    dir_table.push_back(item_row(CMD_QUERY,  64'd2, 64'd1, CHK_MODEL));
    dir_table.push_back(item_row(CMD_INSERT, 64'h8000_0000_0000_0000,
                                 64'h8000_0000_0000_0000, CHK_MODEL));
    dir_table.push_back(item_row(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA,
                                 64'h5555_5555_5555_5555, CHK_MODEL));
    dir_table.push_back(item_row(CMD_QUERY,  64'hAAAA_AAAA_AAAA_AAAA,
                                 64'h5555_5555_5555_5555, CHK_PRESENT));
    dir_table.push_back(item_row(CMD_QUERY,  64'h5555_5555_5555_5555,
                                 64'hAAAA_AAAA_AAAA_AAAA, CHK_MODEL));
    // bit count zero acts as one: every probe lands on bit 0
    dir_table.push_back(cfg_row(REG_BIT_COUNT, 21'd0));
    dir_table.push_back(item_row(CMD_QUERY,  64'h0123_4567_89AB_CDEF,
                                 64'hFEDC_BA98_7654_3210, CHK_PRESENT));
    dir_table.push_back(item_row(CMD_INSERT, 64'h0123_4567_89AB_CDEF,
                                 64'hFEDC_BA98_7654_3210, CHK_MODEL));
    // oversized bit count and probe count saturate
    dir_table.push_back(cfg_row(REG_BIT_COUNT, 21'h1F_FFFF));
    dir_table.push_back(cfg_row(REG_PROBE_COUNT, 21'h1F_FFFF));
    dir_table.push_back(item_row(CMD_INSERT, 64'd7, 64'd3, CHK_MODEL));
    dir_table.push_back(item_row(CMD_QUERY,  64'd7, 64'd3, CHK_PRESENT));
    dir_table.push_back(item_row(CMD_QUERY,  64'd7, 64'd4, CHK_MODEL));
    // zero probes: nothing stored, every query reads as present
    dir_table.push_back(cfg_row(REG_PROBE_COUNT, 21'h1F_FFC0));
    dir_table.push_back(item_row(CMD_QUERY,  64'hDEAD_BEEF_0000_0001, 64'd1, CHK_PRESENT));
    dir_table.push_back(item_row(CMD_INSERT, 64'hFFFF_FFFF_0000_0000, 64'd5, CHK_MODEL));
    // writes past the register list leave the probe count at zero
    dir_table.push_back(cfg_row(REG_SPARE_2, 21'd1));
    dir_table.push_back(cfg_row(REG_SPARE_3, 21'd5));
    dir_table.push_back(item_row(CMD_QUERY,  64'h0000_0000_0000_BEEF, 64'd2, CHK_PRESENT));
    dir_table.push_back(cfg_row(REG_BIT_COUNT, 21'd1));
    dir_table.push_back(cfg_row(REG_PROBE_COUNT, 21'd32));
    dir_table.push_back(item_row(CMD_QUERY,  64'h1357_9BDF_2468_ACE0, H_ONES, CHK_PRESENT));
    // odd modulus, single probe
    dir_table.push_back(cfg_row(REG_BIT_COUNT, 21'd1048575));
    dir_table.push_back(cfg_row(REG_PROBE_COUNT, 21'd1));
    dir_table.push_back(item_row(CMD_QUERY,  H_ONES, H_ZERO, CHK_MODEL));
    dir_table.push_back(item_row(CMD_INSERT, H_ONES, H_ZERO, CHK_MODEL));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows; the first beats wait out the clearing sweep
    foreach (dir_table[r]) begin
      if (dir_table[r].kind == ROW_CFG) begin
        wait_drained();
        write_reg(dir_table[r].idx, dir_table[r].data);
      end else begin
        drive_item(dir_table[r].cmd, dir_table[r].a, dir_table[r].b, dir_table[r].chk);
      end
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin bits = 21'd64;      probes = 6'd9;  end
        1: begin bits = 21'd1;       probes = 6'd63; end
        2: begin bits = 21'd1048576; probes = 6'd32; end
        3: begin bits = 21'd1000;    probes = 6'd0;  end
        4: begin bits = 21'd4096;    probes = 6'd1;  end
        NUM_PHASES - 1: begin bits = 21'd1048576; probes = 6'd9; end
        default: begin
          if ($urandom_range(0, 3) == 0) bits = 21'($urandom);
          else bits = 21'($urandom_range(1, 20000));
          probes = 6'($urandom_range(0, 63));
        end
      endcase
      wait_drained();
      write_reg(REG_BIT_COUNT, bits);
      write_reg(REG_PROBE_COUNT, {15'($urandom), probes});
      key_pool.delete();
      if (ph == NUM_PHASES - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 15 * $urandom_range(0, 2);
        recv_idle_pct = 15 * $urandom_range(0, 2);
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 40 || key_pool.size() == 0) begin
          // fresh key in, remembered for later lookups
          key.a = rand_hash();
          key.b = rand_hash();
          if (key_pool.size() >= POOL_MAX) void'(key_pool.pop_front());
          key_pool.push_back(key);
          drive_item(CMD_INSERT, key.a, key.b, CHK_MODEL);
        end else if (roll < 75) begin
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
          drive_item(CMD_QUERY, key.a, key.b, CHK_MODEL);
        end else if (roll < 85) begin
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
          drive_item(CMD_INSERT, key.a, key.b, CHK_MODEL);
        end else begin
          drive_item(CMD_QUERY, rand_hash(), rand_hash(), CHK_MODEL);
        end
      end
    end

    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("bloom_filter_double_hash_test: PASS");
    end else begin
      $display("bloom_filter_double_hash_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bfdh_pkg.sv
rtl/core/bfdh_modred.sv
rtl/core/bfdh_store.sv
rtl/core/bloom_filter_double_hash.sv
rtl/core/bfdh_checker.sv
test/bloom_filter_double_hash_test.sv
